// ----- hw/rtl/pkrl_pkg.sv -----
`default_nettype none
package pkrl_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 256;

	localparam logic [7:0]  BURST_COUNT_RST    = 8'd3;
	localparam logic [31:0] BURST_WINDOW_RST   = 32'd60000;
	localparam logic [31:0] LIMIT_INTERVAL_RST = 32'd5000;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [1:0] FUNC_CHECK     = 2'd0;
	localparam logic [1:0] FUNC_FLUSH_ONE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH_ALL = 2'd2;

	typedef struct packed {
		logic [7:0]  burst_count;
		logic [31:0] burst_window_ms;
		logic [31:0] limit_interval_ms;
	} cfg_t;

	// first member sits in the high bits: func ends up at bit 0
	typedef struct packed {
		logic [31:0] now_ms;
		logic [63:0] client_key;
		logic [1:0]  func;
	} req_t;

	typedef struct packed {
		logic       evicted;
		logic [7:0] attempt_count;
		logic       found;
		logic       accepted;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  count;
		logic [31:0] time_ms;
		logic [63:0] key;
	} entry_t;

	localparam int unsigned REQ_W      = $bits(req_t);
	localparam int unsigned RES_W      = $bits(res_t);
	localparam int unsigned ENTRY_W    = $bits(entry_t);
	localparam int unsigned S_TDATA_W  = ((REQ_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W  = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// ----- hw/rtl/pkrl_ram.sv -----
`default_nettype none
module pkrl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/pkrl_cfg.sv -----
`default_nettype none
module pkrl_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pkrl_pkg::APB_AW-1:0]  paddr,
	input  wire logic [pkrl_pkg::APB_DW-1:0]  pwdata,
	output logic      [pkrl_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	output pkrl_pkg::cfg_t                    cfg
);

	localparam logic [1:0] REG_BURST_COUNT    = 2'd0;
	localparam logic [1:0] REG_BURST_WINDOW   = 2'd1;
	localparam logic [1:0] REG_LIMIT_INTERVAL = 2'd2;

	pkrl_pkg::cfg_t cfg_q;
	logic [1:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_count       <= pkrl_pkg::BURST_COUNT_RST;
			cfg_q.burst_window_ms   <= pkrl_pkg::BURST_WINDOW_RST;
			cfg_q.limit_interval_ms <= pkrl_pkg::LIMIT_INTERVAL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BURST_COUNT:    cfg_q.burst_count       <= pwdata[7:0];
				REG_BURST_WINDOW:   cfg_q.burst_window_ms   <= pwdata;
				REG_LIMIT_INTERVAL: cfg_q.limit_interval_ms <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BURST_COUNT:    prdata = {24'd0, cfg_q.burst_count};
			REG_BURST_WINDOW:   prdata = cfg_q.burst_window_ms;
			REG_LIMIT_INTERVAL: prdata = cfg_q.limit_interval_ms;
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/pkrl_engine.sv -----
`default_nettype none
module pkrl_engine #(
	parameter int unsigned TABLE_ENTRIES = pkrl_pkg::TABLE_ENTRIES_DEF,
	localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pkrl_pkg::cfg_t  cfg,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire pkrl_pkg::req_t  req,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output pkrl_pkg::res_t       res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output pkrl_pkg::entry_t     mem_wdata,
	output logic [AW-1:0]        mem_raddr,
	input  wire pkrl_pkg::entry_t mem_rdata
);

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]     state_q;
	logic [AW-1:0]  addr_q;
	logic           issue_done_q;
	logic           item_q;
	logic           rd_vld_s1;
	logic           rd_last_s1;
	logic [AW-1:0]  rd_idx_s1;
	logic           hit_q;
	logic           free_q;

	pkrl_pkg::req_t req_q;
	pkrl_pkg::res_t res_q;
	logic [AW-1:0]  hit_idx_q;
	logic [31:0]    hit_time_q;
	logic [7:0]     hit_count_q;
	logic [AW-1:0]  free_idx_q;
	logic [31:0]    old_age_q;
	logic [AW-1:0]  old_idx_q;
	logic           found_q;

	// per-entry evaluation during the walk
	logic           is_check;
	logic [31:0]    age_e;
	logic           key_eq;
	logic           stale_e;
	logic           clr_e;

	// final update of the selected slot
	logic [31:0]    age_h;
	logic           live_h;
	logic [7:0]     cnt_inc;
	logic [7:0]     fin_count;
	logic [31:0]    fin_time;
	logic           fin_acc;
	logic [AW-1:0]  fin_slot;
	logic           fin_evict;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;
	assign mem_raddr = addr_q;

	assign is_check = (req_q.func == pkrl_pkg::FUNC_CHECK);
	assign age_e    = req_q.now_ms - mem_rdata.time_ms;
	assign key_eq   = (mem_rdata.key == req_q.client_key);
	assign stale_e  = (age_e > cfg.burst_window_ms);
	assign clr_e    = rd_vld_s1 && mem_rdata.valid &&
		(is_check ? (!key_eq && stale_e) : (key_eq && !hit_q));

	assign age_h   = req_q.now_ms - hit_time_q;
	assign live_h  = hit_q && (age_h <= cfg.burst_window_ms);
	assign cnt_inc = (hit_count_q == 8'hFF) ? hit_count_q : hit_count_q + 8'd1;

	always_comb begin
		fin_count = 8'd0;
		fin_time  = req_q.now_ms;
		fin_acc   = 1'b1;
		fin_slot  = hit_idx_q;
		fin_evict = 1'b0;
		if (live_h) begin
			if (age_h < cfg.burst_window_ms) begin
				fin_count = cnt_inc;
				if (cnt_inc >= cfg.burst_count && age_h < cfg.limit_interval_ms) begin
					fin_time = hit_time_q;
					fin_acc  = 1'b0;
				end else if (cnt_inc < cfg.burst_count) begin
					fin_time = hit_time_q;
				end
			end
		end else if (!hit_q) begin
			fin_slot  = free_q ? free_idx_q : old_idx_q;
			fin_evict = !free_q;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_SCAN: begin
				mem_we    = clr_e;
				mem_waddr = rd_idx_s1;
			end
			ST_FINAL: begin
				mem_we            = is_check;
				mem_waddr         = fin_slot;
				mem_wdata.valid   = 1'b1;
				mem_wdata.count   = fin_count;
				mem_wdata.time_ms = fin_time;
				mem_wdata.key     = req_q.client_key;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			item_q       <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_IDX) begin
						state_q <= item_q ? ST_OUT : ST_IDLE;
						item_q  <= 1'b0;
						addr_q  <= '0;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						addr_q       <= '0;
						issue_done_q <= 1'b0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						unique case (req.func) inside
							pkrl_pkg::FUNC_CHECK, pkrl_pkg::FUNC_FLUSH_ONE: state_q <= ST_SCAN;
							pkrl_pkg::FUNC_FLUSH_ALL: begin
								state_q <= ST_CLEAR;
								item_q  <= 1'b1;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						if (addr_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (rd_vld_s1 && mem_rdata.valid && key_eq && (is_check || !hit_q)) begin
						hit_q <= 1'b1;
					end
					if (rd_vld_s1 && is_check && !free_q && (!mem_rdata.valid || clr_e)) begin
						free_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_last_s1) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
						addr_q  <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= addr_q;
		rd_last_s1 <= (addr_q == LAST_IDX);
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
			res_q <= '0;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (mem_rdata.valid && key_eq) begin
				if (is_check) begin
					hit_idx_q   <= rd_idx_s1;
					hit_time_q  <= mem_rdata.time_ms;
					hit_count_q <= mem_rdata.count;
				end else if (!hit_q) begin
					found_q <= !stale_e;
				end
			end
			if (is_check && !free_q && (!mem_rdata.valid || clr_e)) begin
				free_idx_q <= rd_idx_s1;
			end
			if (rd_idx_s1 == '0 || age_e > old_age_q) begin
				old_age_q <= age_e;
				old_idx_q <= rd_idx_s1;
			end
		end
		if (state_q == ST_FINAL) begin
			if (is_check) begin
				res_q.accepted      <= fin_acc;
				res_q.found         <= live_h;
				res_q.attempt_count <= live_h ? fin_count : 8'd0;
				res_q.evicted       <= fin_evict;
			end else begin
				res_q.accepted      <= 1'b0;
				res_q.found         <= hit_q && found_q;
				res_q.attempt_count <= 8'd0;
				res_q.evicted       <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/per_key_burst_rate_limiter.sv -----
`default_nettype none
// Channel  | Dir  | Beat / fields (low bit first)
// s_axis   | in   | tdata: func[1:0], client_key[65:2], now_ms[97:66], zero pad
// m_axis   | out  | tdata: accepted[0], found[1], attempt_count[9:2], evicted[10], zero pad
// apb      | in   | 0x0 burst_count, 0x4 burst_window_ms, 0x8 limit_interval_ms
//
// Check and flush-one walk the whole key table through the entry RAM read
// port, one entry per cycle. Flush-all sweeps the RAM write port.
// After reset the same sweep clears the table; s_axis_tready stays low
// until it ends. One request at a time; the output register lets the
// next request start while a result waits on m_axis_tready.
module per_key_burst_rate_limiter #(
	parameter int unsigned TABLE_ENTRIES = pkrl_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// func, client_key, now_ms
	input  wire logic [pkrl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// accepted, found, attempt_count, evicted
	output logic      [pkrl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pkrl_pkg::APB_AW-1:0]      paddr,
	input  wire logic [pkrl_pkg::APB_DW-1:0]      pwdata,
	output logic      [pkrl_pkg::APB_DW-1:0]      prdata,
	output logic                                  pready
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);

	pkrl_pkg::cfg_t   cfg;
	pkrl_pkg::req_t   req;
	pkrl_pkg::res_t   res;
	pkrl_pkg::entry_t mem_wdata;
	pkrl_pkg::entry_t mem_rdata;
	logic             res_valid;
	logic             res_ready;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	logic             m_tvalid_q;
	pkrl_pkg::res_t   m_res_q;

	assign req = pkrl_pkg::req_t'(s_axis_tdata[pkrl_pkg::REQ_W-1:0]);

	pkrl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pkrl_ram #(
		.WIDTH (pkrl_pkg::ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pkrl_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	assign res_ready     = !m_tvalid_q || m_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {{(pkrl_pkg::M_TDATA_W - pkrl_pkg::RES_W){1'b0}}, m_res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

endmodule
`default_nettype wire
